>>> rtl/core/reqq_pkg.sv
package reqq_pkg;

  localparam int SLOT_COUNT_DEFAULT = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CODE_W = 8;
  localparam int LINE_W = 3;
  localparam int LINE_COUNT = 7;

  localparam int IN_DATA_W = 40;
  localparam int OUT_DATA_W = 16;

  localparam logic [LINE_W-1:0] LINE_BUTTON = 3'd6;

  localparam logic [CODE_W-1:0] CODE_VALID = 8'h80;
  localparam logic [CODE_W-1:0] CODE_BUTTON = 8'h40;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [CFG_W-1:0] TIMEIN_RESET = 16'd5;
  localparam logic [CFG_W-1:0] COOLDOWN_RESET = 16'd10;
  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd100;

  typedef enum logic [2:0] {
    STATUS_STORED   = 3'd0,
    STATUS_REJECTED = 3'd1,
    STATUS_FULL     = 3'd2,
    STATUS_UNKNOWN  = 3'd3,
    STATUS_RELEASED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    CFG_TIMEOUT  = 2'd0,
    CFG_TIMEIN   = 2'd1,
    CFG_COOLDOWN = 2'd2,
    CFG_DEBOUNCE = 2'd3
  } cfg_index_t;

  // One classified request as it waits between the front and the back.
  typedef struct packed {
    logic              release_op;
    logic              known;
    logic [LINE_W-1:0] line;
    logic              rising;
    logic [TIME_W-1:0] time_ms;
    logic [2:0]        release_index;
  } item_t;

endpackage

>>> rtl/core/rotary_edge_qualifier_queue_unit.sv
// Channel  Direction  Handshake          Contents
// s_       in         s_tvalid/s_tready  edge event or slot release request
// m_       out        m_tvalid/m_tready  one result per request
// cfg_     in         cfg_we             timing register writes
//
// Sustained rate is one request per cycle while the output is not stalled; the back
// end reads the edge tables and slot queue and updates them as it executes a
// request. A request is written into the queue at the accepting edge and executes
// from its head once the output can take a result, which m_tvalid then shows.
// After reset all edge times, the cooldown mark and the slots are cleared at
// once; no clearing pass. A stalled output holds its result while the request
// queue keeps taking up to four more requests.
module rotary_edge_qualifier_queue_unit #(
  parameter int SLOT_COUNT = reqq_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // s_tdata: pin_number[3:0], rising_edge[4], time_ms[36:5], release_index[39:37]
  input  logic [reqq_pkg::IN_DATA_W-1:0]  s_tdata,
  // s_tuser: operation[0]
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // m_tdata: slot_index[2:0], event_code[10:3], zero fill[15:11]
  output logic [reqq_pkg::OUT_DATA_W-1:0] m_tdata,
  // m_tuser: status[2:0]
  output logic [2:0]                      m_tuser,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [reqq_pkg::CFG_W-1:0]      cfg_data
);

  reqq_pkg::item_t            front_item;
  reqq_pkg::item_t            q_item;
  logic                       q_valid;
  logic                       q_pop;
  logic [2:0]                 slot_index;
  logic [reqq_pkg::CODE_W-1:0] event_code;

  reqq_front u_front (
    .s_tuser (s_tuser),
    .s_tdata (s_tdata),
    .item    (front_item)
  );

  reqq_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_item   (front_item),
    .out_valid (q_valid),
    .out_pop   (q_pop),
    .out_item  (q_item)
  );

  reqq_back #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .status     (m_tuser),
    .slot_index (slot_index),
    .event_code (event_code)
  );

  assign m_tdata = {5'd0, event_code, slot_index};

endmodule

>>> rtl/core/reqq_front.sv
module reqq_front (
  input  logic                            s_tuser,
  input  logic [reqq_pkg::IN_DATA_W-1:0]  s_tdata,
  output reqq_pkg::item_t                 item
);

  localparam logic [3:0] PIN_A1 = 4'd0;
  localparam logic [3:0] PIN_A2 = 4'd3;
  localparam logic [3:0] PIN_B1 = 4'd1;
  localparam logic [3:0] PIN_B2 = 4'd9;
  localparam logic [3:0] PIN_C1 = 4'd10;
  localparam logic [3:0] PIN_C2 = 4'd5;
  localparam logic [3:0] PIN_BUTTON = 4'd6;

  logic [3:0] pin_number;

  assign pin_number = s_tdata[3:0];

  always_comb begin
    item.release_op    = s_tuser;
    item.rising        = s_tdata[4];
    item.time_ms       = s_tdata[36:5];
    item.release_index = s_tdata[39:37];
    item.known         = 1'b1;
    case (pin_number)
      PIN_A1:     item.line = 3'd0;
      PIN_A2:     item.line = 3'd1;
      PIN_B1:     item.line = 3'd2;
      PIN_B2:     item.line = 3'd3;
      PIN_C1:     item.line = 3'd4;
      PIN_C2:     item.line = 3'd5;
      PIN_BUTTON: item.line = reqq_pkg::LINE_BUTTON;
      default: begin
        item.line  = 3'd0;
        item.known = 1'b0;
      end
    endcase
  end

endmodule

>>> rtl/core/reqq_fifo.sv
module reqq_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  reqq_pkg::item_t in_item,
  output logic            out_valid,
  input  logic            out_pop,
  output reqq_pkg::item_t out_item
);

  localparam int DEPTH = reqq_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  reqq_pkg::item_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready  = (count != CNT_W'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_pop && out_valid;
  assign out_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> rtl/core/reqq_back.sv
module reqq_back #(
  parameter int SLOT_COUNT = reqq_pkg::SLOT_COUNT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [reqq_pkg::CFG_W-1:0]  cfg_data,
  input  logic                        q_valid,
  input  reqq_pkg::item_t             q_item,
  output logic                        q_pop,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [2:0]                  status,
  output logic [2:0]                  slot_index,
  output logic [reqq_pkg::CODE_W-1:0] event_code
);

  localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int TW = reqq_pkg::TIME_W;
  localparam int CW = reqq_pkg::CODE_W;
  localparam int PAD_W = TW - reqq_pkg::CFG_W;

  logic [reqq_pkg::CFG_W-1:0] rotation_timeout_ms;
  logic [reqq_pkg::CFG_W-1:0] rotation_timein_ms;
  logic [reqq_pkg::CFG_W-1:0] rotation_cooldown_ms;
  logic [reqq_pkg::CFG_W-1:0] button_debounce_ms;

  logic [TW-1:0]         rise_times [reqq_pkg::LINE_COUNT];
  logic [TW-1:0]         fall_times [reqq_pkg::LINE_COUNT];
  logic [TW-1:0]         last_rotation_time;
  logic [SLOT_COUNT-1:0] slot_full;
  logic [CW-1:0]         slot_codes [SLOT_COUNT];

  logic                  exec;
  logic                  any_empty;
  logic [SLOT_W-1:0]     pick;
  logic [31:0]           pick_wide;
  logic [2:0]            partner;
  logic [TW-1:0]         partner_time;
  logic [TW-1:0]         interval;
  logic [TW-1:0]         since_last;
  logic [TW-1:0]         since_rise;
  logic [TW-1:0]         since_fall;
  logic                  rot_ok;
  logic                  btn_ok;
  logic [CW-1:0]         rot_code;
  logic                  rel_in_range;
  logic [SLOT_W-1:0]     rel_slot;
  logic                  edge_live;
  logic                  do_store;
  logic                  rot_store;
  reqq_pkg::status_t     res_status;
  logic [2:0]            res_slot;
  logic [CW-1:0]         res_code;

  assign exec  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = exec;

  // Highest-numbered empty slot wins: later iterations override earlier ones.
  always_comb begin
    any_empty = 1'b0;
    pick      = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!slot_full[i]) begin
        any_empty = 1'b1;
        pick      = SLOT_W'(i);
      end
    end
  end

  assign pick_wide = 32'(pick);

  assign partner      = (q_item.line == reqq_pkg::LINE_BUTTON) ? 3'd0 : (q_item.line ^ 3'd1);
  assign partner_time = q_item.rising ? rise_times[partner] : fall_times[partner];
  assign interval     = q_item.time_ms - partner_time;
  assign since_last   = q_item.time_ms - last_rotation_time;
  assign since_rise   = q_item.time_ms - rise_times[reqq_pkg::LINE_BUTTON];
  assign since_fall   = q_item.time_ms - fall_times[reqq_pkg::LINE_BUTTON];

  // A negative interval means the partner edge is newer, which never counts.
  assign rot_ok = !interval[TW-1]
                  && (interval < {{PAD_W{1'b0}}, rotation_timeout_ms})
                  && (interval > {{PAD_W{1'b0}}, rotation_timein_ms})
                  && (since_last > {{PAD_W{1'b0}}, rotation_cooldown_ms});
  assign btn_ok = (since_rise > {{PAD_W{1'b0}}, button_debounce_ms})
                  && (since_fall > {{PAD_W{1'b0}}, button_debounce_ms});
  assign rot_code = reqq_pkg::CODE_VALID | (CW'(1) << q_item.line);

  assign rel_in_range = ({29'd0, q_item.release_index} < 32'(SLOT_COUNT));
  assign rel_slot     = SLOT_W'(q_item.release_index);
  assign edge_live    = !q_item.release_op && any_empty && q_item.known;

  always_comb begin
    res_status = reqq_pkg::STATUS_REJECTED;
    res_slot   = 3'd0;
    res_code   = '0;
    do_store   = 1'b0;
    rot_store  = 1'b0;
    if (q_item.release_op) begin
      res_status = reqq_pkg::STATUS_RELEASED;
      res_slot   = q_item.release_index;
      if (rel_in_range && slot_full[rel_slot]) begin
        res_code = slot_codes[rel_slot];
      end
    end else if (!any_empty) begin
      res_status = reqq_pkg::STATUS_FULL;
    end else if (!q_item.known) begin
      res_status = reqq_pkg::STATUS_UNKNOWN;
    end else if (q_item.line == reqq_pkg::LINE_BUTTON) begin
      res_slot = pick_wide[2:0];
      if (q_item.rising && btn_ok) begin
        res_status = reqq_pkg::STATUS_STORED;
        res_code   = reqq_pkg::CODE_VALID | reqq_pkg::CODE_BUTTON;
        do_store   = 1'b1;
      end
    end else begin
      res_slot = pick_wide[2:0];
      if (rot_ok) begin
        res_status = reqq_pkg::STATUS_STORED;
        res_code   = rot_code;
        do_store   = 1'b1;
        rot_store  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_timeout_ms  <= reqq_pkg::TIMEOUT_RESET;
      rotation_timein_ms   <= reqq_pkg::TIMEIN_RESET;
      rotation_cooldown_ms <= reqq_pkg::COOLDOWN_RESET;
      button_debounce_ms   <= reqq_pkg::DEBOUNCE_RESET;
    end else if (cfg_we) begin
      case (reqq_pkg::cfg_index_t'(cfg_index))
        reqq_pkg::CFG_TIMEOUT:  rotation_timeout_ms  <= cfg_data;
        reqq_pkg::CFG_TIMEIN:   rotation_timein_ms   <= cfg_data;
        reqq_pkg::CFG_COOLDOWN: rotation_cooldown_ms <= cfg_data;
        reqq_pkg::CFG_DEBOUNCE: button_debounce_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Edge time tables. A rotary edge also clears the line's opposite entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < reqq_pkg::LINE_COUNT; i++) begin
        rise_times[i] <= '0;
        fall_times[i] <= '0;
      end
      last_rotation_time <= '0;
    end else if (exec && edge_live) begin
      if (q_item.line == reqq_pkg::LINE_BUTTON) begin
        if (q_item.rising) begin
          rise_times[reqq_pkg::LINE_BUTTON] <= q_item.time_ms;
        end else begin
          fall_times[reqq_pkg::LINE_BUTTON] <= q_item.time_ms;
        end
      end else if (q_item.rising) begin
        rise_times[q_item.line] <= q_item.time_ms;
        fall_times[q_item.line] <= '0;
      end else begin
        fall_times[q_item.line] <= q_item.time_ms;
        rise_times[q_item.line] <= '0;
      end
      if (rot_store) begin
        last_rotation_time <= q_item.time_ms;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (exec && do_store) begin
      slot_codes[pick] <= res_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_full <= '0;
    end else if (exec) begin
      if (do_store) begin
        slot_full[pick] <= 1'b1;
      end else if (q_item.release_op && rel_in_range) begin
        slot_full[rel_slot] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      status     <= res_status;
      slot_index <= res_slot;
      event_code <= res_code;
    end
  end

endmodule

>>> rtl/core/reqq_checker.sv
module reqq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [reqq_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [2:0]                      m_tuser
);

  // A stalled result must hold until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A stored event always carries the valid bit of its code.
  a_stored_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == reqq_pkg::STATUS_STORED) |-> m_tdata[10])
    else $error("stored event without valid code");

  a_no_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == reqq_pkg::STATUS_REJECTED) || (m_tuser == reqq_pkg::STATUS_FULL)
                 || (m_tuser == reqq_pkg::STATUS_UNKNOWN)) |-> (m_tdata[10:3] == 8'd0))
    else $error("event code on a result that stored nothing");

  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && ((m_tuser == reqq_pkg::STATUS_FULL) || (m_tuser == reqq_pkg::STATUS_UNKNOWN))
    |-> (m_tdata[2:0] == 3'd0))
    else $error("slot index on a result that used no slot");

endmodule

bind rotary_edge_qualifier_queue_unit reqq_checker u_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int SLOTS = reqq_pkg::SLOT_COUNT_DEFAULT;
  localparam int QUIET_LIMIT = 5000;
  localparam logic [3:0] BUTTON_PIN = 4'd6;
  // Pins by line number: encoder A lines, encoder B lines, encoder C lines.
  localparam logic [3:0] ENC_PINS [6] = '{4'd0, 4'd3, 4'd1, 4'd9, 4'd10, 4'd5};

  typedef struct packed {
    reqq_pkg::status_t status;
    logic [2:0]        slot;
    logic [7:0]        code;
  } slot_result_t;

  logic                            clk;
  logic                            rst;
  logic                            s_tvalid;
  logic                            s_tready;
  // s_tdata: pin_number[3:0], rising_edge[4], time_ms[36:5], release_index[39:37]
  logic [reqq_pkg::IN_DATA_W-1:0]  s_tdata;
  // s_tuser: operation[0]
  logic                            s_tuser;
  logic                            m_tvalid;
  logic                            m_tready;
  // m_tdata: slot_index[2:0], event_code[10:3], zero fill[15:11]
  logic [reqq_pkg::OUT_DATA_W-1:0] m_tdata;
  // m_tuser: status[2:0]
  logic [2:0]                      m_tuser;
  logic                            cfg_we;
  logic [1:0]                      cfg_index;
  logic [reqq_pkg::CFG_W-1:0]      cfg_data;

  // Shadow copy of the qualifier state.
  logic [31:0] rise_ms [reqq_pkg::LINE_COUNT];
  logic [31:0] fall_ms [reqq_pkg::LINE_COUNT];
  logic [31:0] last_turn_ms;
  logic [7:0]  slot_codes [SLOTS];
  logic [15:0] timeout_ms;
  logic [15:0] timein_ms;
  logic [15:0] cooldown_ms;
  logic [15:0] debounce_ms;

  slot_result_t expected_q[$];
  logic [31:0]  now_ms;
  int           items_sent;
  int           fail_count;
  int           quiet_cycles;
  int           stall_left;
  bit           in_gaps_on;
  bit           out_stall_on;

  rotary_edge_qualifier_queue_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int pin_to_line(logic [3:0] pin);
    case (pin)
      4'd0:  return 0;
      4'd3:  return 1;
      4'd1:  return 2;
      4'd9:  return 3;
      4'd10: return 4;
      4'd5:  return 5;
      4'd6:  return int'(reqq_pkg::LINE_BUTTON);
      default: return -1;
    endcase
  endfunction

  function automatic slot_result_t qualify_edge(bit op, logic [3:0] pin, bit rise,
                                                logic [31:0] t, logic [2:0] ridx);
    slot_result_t r;
    int          free_slot;
    int          ln;
    int          mate;
    logic [31:0] span;
    logic [31:0] since_rise;
    logic [31:0] since_fall;
    logic [31:0] since_turn;
    r.status = reqq_pkg::STATUS_RELEASED;
    r.slot   = ridx;
    r.code   = '0;
    if (op) begin
      r.code = slot_codes[ridx];
      slot_codes[ridx] = '0;
      return r;
    end
    free_slot = -1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (free_slot < 0 && slot_codes[i] == 8'd0) free_slot = i;
    end
    r.slot = '0;
    if (free_slot < 0) begin
      r.status = reqq_pkg::STATUS_FULL;
      return r;
    end
    ln = pin_to_line(pin);
    if (ln < 0) begin
      r.status = reqq_pkg::STATUS_UNKNOWN;
      return r;
    end
    r.slot   = free_slot[2:0];
    r.status = reqq_pkg::STATUS_REJECTED;
    if (ln == reqq_pkg::LINE_BUTTON) begin
      if (rise) begin
        since_rise = t - rise_ms[ln];
        since_fall = t - fall_ms[ln];
        rise_ms[ln] = t;
        if (since_rise > debounce_ms && since_fall > debounce_ms) begin
          r.status = reqq_pkg::STATUS_STORED;
          r.code   = reqq_pkg::CODE_VALID | reqq_pkg::CODE_BUTTON;
        end
      end else begin
        fall_ms[ln] = t;
      end
    end else begin
      mate = ln ^ 1;
      if (rise) begin
        rise_ms[ln] = t;
        fall_ms[ln] = '0;
        span = t - rise_ms[mate];
      end else begin
        fall_ms[ln] = t;
        rise_ms[ln] = '0;
        span = t - fall_ms[mate];
      end
      since_turn = t - last_turn_ms;
      // The partner interval counts as signed: an edge older than its partner never qualifies.
      if (!span[31] && span < timeout_ms && span > timein_ms && since_turn > cooldown_ms) begin
        r.status = reqq_pkg::STATUS_STORED;
        r.code   = reqq_pkg::CODE_VALID | (8'd1 << ln);
        last_turn_ms = t;
      end
    end
    if (r.status == reqq_pkg::STATUS_STORED) slot_codes[free_slot] = r.code;
    return r;
  endfunction

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Values around an open interval, weighted toward its two bounds.
  function automatic logic [31:0] near_window(logic [31:0] lo, logic [31:0] hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return lo + 1;
      2: return hi - 1;
      3: return hi;
      7: return $urandom_range(0, hi + hi + 2);
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  task automatic send_request(input bit op, input logic [3:0] pin, input bit rise,
                              input logic [31:0] t, input logic [2:0] ridx);
    int gap;
    gap = (in_gaps_on && $urandom_range(0, 99) >= 60) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {ridx, t, rise, pin};
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(qualify_edge(op, pin, rise, t, ridx));
    items_sent++;
  endtask

  task automatic push_edge(input logic [3:0] pin, input bit rise, input logic [31:0] t);
    send_request(1'b0, pin, rise, t, 3'($urandom_range(0, 7)));
  endtask

  task automatic release_slot(input logic [2:0] idx);
    send_request(1'b1, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom(), idx);
  endtask

  task automatic sender_idle();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  task automatic wait_idle();
    sender_idle();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input reqq_pkg::cfg_index_t idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_timing(input logic [15:0] tmo, input logic [15:0] tin,
                            input logic [15:0] cool, input logic [15:0] deb);
    wait_idle();
    put_reg(reqq_pkg::CFG_TIMEOUT, tmo);
    put_reg(reqq_pkg::CFG_TIMEIN, tin);
    put_reg(reqq_pkg::CFG_COOLDOWN, cool);
    put_reg(reqq_pkg::CFG_DEBOUNCE, deb);
    @(negedge clk);
    cfg_we <= 1'b0;
    timeout_ms  = tmo;
    timein_ms   = tin;
    cooldown_ms = cool;
    debounce_ms = deb;
  endtask

  // One quadrature step: an edge on one line, then the same edge on its partner.
  task automatic random_turn();
    int enc;
    bit rise;
    bit lead;
    enc  = $urandom_range(0, 2);
    rise = 1'($urandom_range(0, 1));
    lead = 1'($urandom_range(0, 1));
    now_ms += $urandom_range(0, cooldown_ms + 3);
    push_edge(ENC_PINS[2 * enc + lead], rise, now_ms);
    now_ms += near_window(32'(timein_ms), 32'(timeout_ms));
    push_edge(ENC_PINS[2 * enc + (lead ^ 1)], rise, now_ms);
  endtask

  task automatic random_item();
    int occupied[$];
    int roll;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_codes[i] != 8'd0) occupied.push_back(i);
    end
    roll = $urandom_range(0, 99);
    if (roll < 10 + 8 * occupied.size()) begin
      if (occupied.size() > 0 && $urandom_range(0, 4) != 0)
        release_slot(3'(occupied[$urandom_range(0, occupied.size() - 1)]));
      else
        release_slot(3'($urandom_range(0, 7)));
    end else if (roll < 70) begin
      random_turn();
    end else if (roll < 85) begin
      now_ms += near_window(32'(debounce_ms), 32'(debounce_ms) + 32'(debounce_ms) + 32'd1);
      push_edge(BUTTON_PIN, $urandom_range(0, 2) != 0, now_ms);
    end else if (roll < 92) begin
      now_ms += $urandom_range(0, timeout_ms + timeout_ms + 2);
      push_edge(ENC_PINS[$urandom_range(0, 5)], 1'($urandom_range(0, 1)), now_ms);
    end else begin
      push_edge(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), $urandom());
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) random_item();
  endtask

  task automatic test_rotary_window();
    push_edge(ENC_PINS[0], 1'b1, 32'd1000);   // partner never moved: far too slow
    push_edge(ENC_PINS[1], 1'b1, 32'd1020);   // inside the window
    push_edge(ENC_PINS[0], 1'b0, 32'd1023);
    push_edge(ENC_PINS[1], 1'b0, 32'd1026);   // too close to the partner edge
    push_edge(ENC_PINS[2], 1'b1, 32'd1010);
    push_edge(ENC_PINS[3], 1'b1, 32'd1025);   // good interval, cooldown still running
    push_edge(ENC_PINS[4], 1'b1, 32'd2000);
    push_edge(ENC_PINS[5], 1'b1, 32'd1990);   // partner edge lies in the future
    push_edge(ENC_PINS[5], 1'b1, 32'd2499);   // one below the timeout
    push_edge(ENC_PINS[4], 1'b0, 32'hFFFF_FFF0);
    push_edge(ENC_PINS[5], 1'b0, 32'h0000_0010); // interval spans the counter wrap
  endtask

  task automatic test_button_debounce();
    push_edge(BUTTON_PIN, 1'b1, 32'd50);
    push_edge(BUTTON_PIN, 1'b1, 32'd300);
    push_edge(BUTTON_PIN, 1'b0, 32'd350);
    push_edge(BUTTON_PIN, 1'b1, 32'd420);     // bounce after the release
  endtask

  task automatic test_unknown_pins();
    push_edge(4'd2, 1'b1, $urandom());
    push_edge(4'd15, 1'b0, $urandom());
    push_edge(4'd7, 1'b1, $urandom());
  endtask

  task automatic test_queue_full();
    int guard;
    now_ms = 32'd5000;
    guard  = 0;
    while (guard < SLOTS && slot_codes[0] == 8'd0) begin
      now_ms += 32'd200;
      push_edge(BUTTON_PIN, 1'b1, now_ms);
      guard++;
    end
    push_edge(ENC_PINS[1], 1'b1, now_ms + 32'd20);
    push_edge(4'd8, 1'b1, now_ms + 32'd30);    // unknown pin loses to the full queue
    release_slot(3'd7);
    release_slot(3'd0);
    release_slot(3'd0);                        // now empty
  endtask

  task automatic test_reset_timing_traffic();
    now_ms = 32'd10000;
    run_random(100);
  endtask

  task automatic test_zero_timing();
    set_timing(16'd0, 16'd0, 16'd0, 16'd0);
    run_random(50);
  endtask

  task automatic test_full_scale_timing();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    in_gaps_on   = 1'b0;
    out_stall_on = 1'b0;
    now_ms = 32'hFFF0_0000;
    run_random(50);
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
  endtask

  task automatic test_wide_window();
    set_timing(16'hFFFF, 16'd0, 16'd0, 16'd0);
    run_random(60);
  endtask

  task automatic test_random_timing();
    logic [15:0] tmo;
    for (int round = 0; round < 3; round++) begin
      tmo = 16'($urandom_range(1, 2000));
      set_timing(tmo, 16'($urandom_range(0, tmo)), 16'($urandom_range(0, 300)),
                 16'($urandom_range(0, 400)));
      run_random(25);
      wait_idle();
      run_random(25);
    end
  endtask

  always @(posedge clk) begin
    slot_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected transaction: status %0d slot %0d code %02h",
                   m_tuser, m_tdata[2:0], m_tdata[10:3]);
      end else begin
        want = expected_q.pop_front();
        if (m_tuser !== want.status || m_tdata[2:0] !== want.slot ||
            m_tdata[10:3] !== want.code) begin
          fail_count++;
          if (fail_count <= 10)
            $display("mismatch: expected %0d/%0d/%02h, got %0d/%0d/%02h (status/slot/code)",
                     want.status, want.slot, want.code, m_tuser, m_tdata[2:0], m_tdata[10:3]);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (out_stall_on && stall_left == 0 && $urandom_range(0, 3) == 0) stall_left = idle_len();
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    in_gaps_on   = 1'b1;
    out_stall_on = 1'b1;
    stall_left   = 0;
    items_sent   = 0;
    fail_count   = 0;
    quiet_cycles = 0;
    now_ms       = '0;
    last_turn_ms = '0;
    timeout_ms   = reqq_pkg::TIMEOUT_RESET;
    timein_ms    = reqq_pkg::TIMEIN_RESET;
    cooldown_ms  = reqq_pkg::COOLDOWN_RESET;
    debounce_ms  = reqq_pkg::DEBOUNCE_RESET;
    for (int i = 0; i < reqq_pkg::LINE_COUNT; i++) begin
      rise_ms[i] = '0;
      fall_ms[i] = '0;
    end
    for (int i = 0; i < SLOTS; i++) slot_codes[i] = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_rotary_window();
    test_button_debounce();
    test_unknown_pins();
    test_queue_full();
    test_reset_timing_traffic();
    test_zero_timing();
    test_full_scale_timing();
    test_wide_window();
    test_random_timing();

    wait_idle();
    repeat (6) @(posedge clk);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
